// File: rtl/bpit_pkg.sv
// package for the barycentric point-in-triangle core: widths, payload types, edge codes
// no dependencies
`default_nettype none
package bpit_pkg;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_BITS = 24;
    // differences, products, sums of two products, three-term sums
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int NC_BITS   = SUM_BITS + 2;
    localparam int MAG_BITS  = NC_BITS;
    // quotient register: integer part capped at the weight range plus guard
    localparam int QUO_BITS  = WEIGHT_BITS + 2;
    localparam int DIV_STEPS = MAG_BITS + FRAC_BITS;

    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX =
        {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN =
        {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_GAMMA = 2'd1,
        EDGE_ALPHA = 2'd2,
        EDGE_BETA  = 2'd3
    } edge_code_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } tri_req_t;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight_a;
        logic signed [WEIGHT_BITS-1:0] weight_b;
        logic signed [WEIGHT_BITS-1:0] weight_c;
        logic                          inside_res;
        logic                          on_edge;
        logic [1:0]                    edge_code;
        logic                          degenerate;
    } tri_res_t;

    // per-item flags that ride along the divider pipeline
    typedef struct packed {
        logic       degenerate;
        logic       inside_res;
        logic       on_edge;
        edge_code_t edge_code;
    } tri_flags_t;

    // saturate a signed quotient magnitude with sign into the weight range
    function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
        input logic [QUO_BITS-1:0] q, input logic neg, input logic ovf);
        logic big;
        big = ovf || (q > QUO_BITS'(WEIGHT_MAX));
        if (neg)
        begin
            if (ovf || q >= QUO_BITS'({1'b1, {(WEIGHT_BITS-1){1'b0}}}))
                sat_weight = WEIGHT_MIN;
            else
                sat_weight = -$signed(q[WEIGHT_BITS-1:0]);
        end
        else
        begin
            sat_weight = big ? WEIGHT_MAX : $signed(q[WEIGHT_BITS-1:0]);
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/bpit_if.sv
// valid/ready channel interfaces for the triangle requests and results
// depends on bpit_pkg
`default_nettype none
interface bpit_req_if;
    logic               valid;
    logic               ready;
    bpit_pkg::tri_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpit_res_if;
    logic               valid;
    logic               ready;
    bpit_pkg::tri_res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/bpit_div.sv
// pipelined restoring divider: one quotient bit per stage, magnitudes only
// depends on bpit_pkg
`default_nettype none
module bpit_div (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [bpit_pkg::MAG_BITS-1:0]  num,
    input  wire logic [bpit_pkg::MAG_BITS-1:0]  den,
    output logic      [bpit_pkg::QUO_BITS-1:0]  quo,
    output logic                                ovf
);
    localparam int N = bpit_pkg::DIV_STEPS;
    localparam int M = bpit_pkg::MAG_BITS;
    localparam int Q = bpit_pkg::QUO_BITS;

    // one stage per quotient bit, dividend bits shifted in msb first
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [M:0]   rem_in;
        logic [M-1:0] num_in;
        logic [M-1:0] den_in;
        logic [Q-1:0] quo_in;
        logic         ovf_in;
        logic [M:0]   rem_reg;
        logic [M-1:0] num_reg;
        logic [M-1:0] den_reg;
        logic [Q-1:0] quo_reg;
        logic         ovf_reg;
        logic [M:0]   sh;
        logic [M+1:0] diff;
        logic         take;

        // first stage starts from the operands, the others from the stage before
        if (s == 0)
        begin : g_src
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign ovf_in = 1'b0;
        end
        else
        begin : g_src
            assign rem_in = g_stage[s-1].rem_reg;
            assign num_in = g_stage[s-1].num_reg;
            assign den_in = g_stage[s-1].den_reg;
            assign quo_in = g_stage[s-1].quo_reg;
            assign ovf_in = g_stage[s-1].ovf_reg;
        end

        always_comb
        begin
            sh   = {rem_in[M-1:0], (s < M) ? num_in[M-1-((s < M) ? s : 0)] : 1'b0};
            diff = {1'b0, sh} - {2'b0, den_in};
            take = !diff[M+1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= take ? diff[M:0] : sh;
                num_reg <= num_in;
                den_reg <= den_in;
                quo_reg <= {quo_in[Q-2:0], take};
                ovf_reg <= ovf_in || quo_in[Q-1];
            end
        end
    end

    assign quo = g_stage[N-1].quo_reg;
    assign ovf = g_stage[N-1].ovf_reg;
endmodule
`default_nettype wire

// File: rtl/barycentric_point_in_triangle_core.sv
// top level of the barycentric point-in-triangle core
// depends on bpit_pkg, bpit_if, bpit_div
`default_nettype none
// Streaming point-in-triangle test. One request (three vertices and a query
// point) is taken per clock while the pipeline advances, and one result comes
// out per request, in order. The pipeline has two stages of subtract and
// multiply, one stage of sums, one stage of exact sign and zero tests, then
// two restoring dividers with one quotient bit per stage, and a saturation
// stage. The whole pipeline advances together and holds while the output
// register is full and not taken, so throughput is one result per cycle when
// the sink keeps ready high.
module barycentric_point_in_triangle_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bpit_req_if.sink    req,
    bpit_res_if.source  res
);
    localparam int D = bpit_pkg::DIFF_BITS;
    localparam int P = bpit_pkg::PROD_BITS;
    localparam int S = bpit_pkg::SUM_BITS;
    localparam int C = bpit_pkg::NC_BITS;
    localparam int M = bpit_pkg::MAG_BITS;
    localparam int W = bpit_pkg::WEIGHT_BITS;
    localparam int LAT = bpit_pkg::DIV_STEPS + 3;

    logic en;
    logic [LAT:0] vld_reg;
    logic out_vld_reg;

    // pipeline advances unless a result waits unclaimed
    assign en        = !out_vld_reg || res.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LAT-1:0], req.valid};
            out_vld_reg <= vld_reg[LAT];
        end
    end

    // stage 1: differences
    logic signed [D-1:0] d_bc_y_reg, d_ac_x_reg, d_cb_x_reg, d_ac_y_reg;
    logic signed [D-1:0] d_ca_y_reg, d_pc_x_reg, d_pc_y_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_bc_y_reg <= D'(req.data.by_coord) - D'(req.data.cy);
            d_ac_x_reg <= D'(req.data.ax) - D'(req.data.cx);
            d_cb_x_reg <= D'(req.data.cx) - D'(req.data.bx);
            d_ac_y_reg <= D'(req.data.ay) - D'(req.data.cy);
            d_ca_y_reg <= D'(req.data.cy) - D'(req.data.ay);
            d_pc_x_reg <= D'(req.data.px) - D'(req.data.cx);
            d_pc_y_reg <= D'(req.data.py) - D'(req.data.cy);
        end
    end

    // stage 2: products
    logic signed [P-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= d_bc_y_reg * d_ac_x_reg;
            p1_reg <= d_cb_x_reg * d_ac_y_reg;
            p2_reg <= d_bc_y_reg * d_pc_x_reg;
            p3_reg <= d_cb_x_reg * d_pc_y_reg;
            p4_reg <= d_ca_y_reg * d_pc_x_reg;
            p5_reg <= d_ac_x_reg * d_pc_y_reg;
        end
    end

    // stage 3: numerators and denominator
    logic signed [S-1:0] den_reg, na_reg, nb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= S'(p0_reg) + S'(p1_reg);
            na_reg  <= S'(p2_reg) + S'(p3_reg);
            nb_reg  <= S'(p4_reg) + S'(p5_reg);
        end
    end

    // stage 4: exact tests, magnitudes and signs for the dividers
    logic signed [C-1:0] nc, sa, sb, sc, sd;
    logic                dneg;
    bpit_pkg::tri_flags_t flg;
    always_comb
    begin
        nc   = C'(den_reg) - C'(na_reg) - C'(nb_reg);
        dneg = den_reg[S-1];
        sa   = dneg ? -C'(na_reg) : C'(na_reg);
        sb   = dneg ? -C'(nb_reg) : C'(nb_reg);
        sc   = dneg ? -nc : nc;
        sd   = dneg ? -C'(den_reg) : C'(den_reg);
        flg.degenerate = (den_reg == '0);
        flg.inside_res = !sa[C-1] && sa <= sd && !sb[C-1] && sb <= sd
                         && !sc[C-1] && sc <= sd && !flg.degenerate;
        flg.on_edge    = ((na_reg == '0) || (nb_reg == '0) || (nc == '0))
                         && !flg.degenerate;
        if (flg.degenerate)
            flg.edge_code = bpit_pkg::EDGE_NONE;
        else if (nc == '0)
            flg.edge_code = bpit_pkg::EDGE_GAMMA;
        else if (na_reg == '0)
            flg.edge_code = bpit_pkg::EDGE_ALPHA;
        else if (nb_reg == '0)
            flg.edge_code = bpit_pkg::EDGE_BETA;
        else
            flg.edge_code = bpit_pkg::EDGE_NONE;
    end

    logic [M-1:0] ma_reg, mb_reg, md_reg;
    logic         nega_reg, negb_reg;
    bpit_pkg::tri_flags_t flg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= na_reg[S-1] ? M'(-C'(na_reg)) : M'(C'(na_reg));
            mb_reg   <= nb_reg[S-1] ? M'(-C'(nb_reg)) : M'(C'(nb_reg));
            md_reg   <= M'(sd);
            nega_reg <= na_reg[S-1] ^ dneg;
            negb_reg <= nb_reg[S-1] ^ dneg;
            flg_reg  <= flg;
        end
    end

    // dividers, one quotient bit per stage
    logic [bpit_pkg::QUO_BITS-1:0] qa, qb;
    logic                          oa, ob;
    bpit_div u_div_a (.clk, .en, .num(ma_reg), .den(md_reg), .quo(qa), .ovf(oa));
    bpit_div u_div_b (.clk, .en, .num(mb_reg), .den(md_reg), .quo(qb), .ovf(ob));

    // side band delay matching the divider depth
    logic                 sgn_a_reg [bpit_pkg::DIV_STEPS];
    logic                 sgn_b_reg [bpit_pkg::DIV_STEPS];
    bpit_pkg::tri_flags_t fd_reg    [bpit_pkg::DIV_STEPS];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_a_reg[0] <= nega_reg;
            sgn_b_reg[0] <= negb_reg;
            fd_reg[0]    <= flg_reg;
            for (int i = 1; i < bpit_pkg::DIV_STEPS; i++)
            begin
                sgn_a_reg[i] <= sgn_a_reg[i-1];
                sgn_b_reg[i] <= sgn_b_reg[i-1];
                fd_reg[i]    <= fd_reg[i-1];
            end
        end
    end

    // final stage: saturate, gamma, degenerate clear
    localparam int L = bpit_pkg::DIV_STEPS - 1;
    logic signed [W-1:0] wa, wb;
    logic signed [W+1:0] wc;
    bpit_pkg::tri_res_t  res_next, res_reg;
    always_comb
    begin
        wa = bpit_pkg::sat_weight(qa, sgn_a_reg[L], oa);
        wb = bpit_pkg::sat_weight(qb, sgn_b_reg[L], ob);
        wc = (W+2)'(1) <<< bpit_pkg::FRAC_BITS;
        wc = wc - (W+2)'(wa) - (W+2)'(wb);
        res_next.weight_a   = wa;
        res_next.weight_b   = wb;
        if (wc > (W+2)'(bpit_pkg::WEIGHT_MAX))
            res_next.weight_c = bpit_pkg::WEIGHT_MAX;
        else if (wc < (W+2)'(bpit_pkg::WEIGHT_MIN))
            res_next.weight_c = bpit_pkg::WEIGHT_MIN;
        else
            res_next.weight_c = wc[W-1:0];
        res_next.inside_res = fd_reg[L].inside_res;
        res_next.on_edge    = fd_reg[L].on_edge;
        res_next.edge_code  = fd_reg[L].edge_code;
        res_next.degenerate = fd_reg[L].degenerate;
        if (fd_reg[L].degenerate)
        begin
            res_next.weight_a = '0;
            res_next.weight_b = '0;
            res_next.weight_c = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res.valid = out_vld_reg;
    assign res.data  = res_reg;
endmodule
`default_nettype wire
